FILE: src/emsf_pkg.sv
`timescale 1ns / 1ps

package emsf_pkg;

   // Section framing constants
   localparam logic [7:0]  TABLE_ID       = 8'h3e;
   localparam logic [7:0]  LEN_FLAGS      = 8'hb0;
   localparam logic [7:0]  MPE_FLAGS      = 8'hc1;
   localparam logic [11:0] MAX_LEN_RESET  = 12'd4080;
   localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
   localparam logic [15:0] POS_MAX        = 16'hffff;
   localparam logic [15:0] MAC_BYTES      = 16'd6;
   localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
   localparam logic [7:0]  ETYPE_IPV4_HI  = 8'h08;
   localparam logic [7:0]  ETYPE_IPV4_LO  = 8'h00;

   // Header is 12 bytes, index 0..11; trailer is 4 CRC bytes, index 0..3
   localparam logic [3:0]  HDR_LAST_IDX   = 4'd11;
   localparam logic [3:0]  CRC_LAST_IDX   = 4'd3;

   // MPEG-2 CRC-32
   localparam logic [31:0] CRC_POLY       = 32'h04c11db7;
   localparam logic [31:0] CRC_INIT       = 32'hffffffff;

   // Command queue between front and back
   localparam int          CMD_DEPTH      = 16;
   localparam int          CMD_PTR_W      = $clog2(CMD_DEPTH);

   typedef enum logic [1:0] {
      BK_CMD,
      BK_HDR,
      BK_CRC
   } back_state_type;

   // One unit of work for the back end: a section header or a payload byte
   typedef struct packed {
      logic            is_hdr;
      logic [7:0]      data;
      logic            last;
      logic [11:0]     sec_len;
      logic [5:0][7:0] mac;
   } cmd_type;

   // One CRC update over a byte, MSB first
   function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h000000};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // Byte idx of the MPE section header
   function automatic logic [7:0] hdr_byte(logic [3:0] idx, logic [11:0] sec_len,
                                           logic [5:0][7:0] mac);
      logic [7:0] b;
      case (idx)
         4'd0:    b = TABLE_ID;
         4'd1:    b = LEN_FLAGS | {4'h0, sec_len[11:8]};
         4'd2:    b = sec_len[7:0];
         4'd3:    b = mac[5];
         4'd4:    b = mac[4];
         4'd5:    b = MPE_FLAGS;
         4'd6:    b = 8'h00;
         4'd7:    b = 8'h00;
         4'd8:    b = mac[3];
         4'd9:    b = mac[2];
         4'd10:   b = mac[1];
         4'd11:   b = mac[0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: src/ethernet_to_mpe_section_framer.sv
`timescale 1ns / 1ps
// Ethernet frame to DVB MPE datagram section framer.
// Input queue port (req_push/req_full): one Ethernet byte per transfer with
// the frame length and a last-byte flag. Frames that are too short, longer
// than csr_max_frame_length or not IPv4 are dropped without output.
// Output queue port (rsp_empty/rsp_pop): section bytes in order, the 12-byte
// MPE header, the payload, then the CRC-32 big-endian, rsp_section_end on
// the final CRC byte.
// Config port (csr_valid/csr_ready): csr_ready is always high; write only
// while the block is idle. Reset value of the limit is 4080.
// A section byte passes through the command queue and then the output
// register before it shows on the output. Throughput: one input byte per
// cycle while the command queue has room. The back end emits one byte per
// cycle while the receiver takes them, N + 2 bytes for a kept frame of N
// bytes; a 16-entry command queue absorbs the header burst and CRC tail, and
// req_full rises when it fills. When the receiver stalls, results wait in the
// output register and command queue, and input stalls once the queue is full.
// Synchronous reset empties everything and restores the length limit.
module ethernet_to_mpe_section_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_frame_byte,
   input  logic [15:0] req_frame_length,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_section_byte,
   output logic        rsp_section_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_max_frame_length
);

   emsf_pkg::cmd_type wr_cmd, rd_cmd;
   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;

   // Front: parse and classify frame bytes
   emsf_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_frame_byte       (req_frame_byte),
      .req_frame_length     (req_frame_length),
      .req_last_byte        (req_last_byte),
      .req_full             (req_full),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_frame_length (csr_max_frame_length),
      .cmd_full             (cmd_full),
      .cmd_push             (cmd_push),
      .cmd                  (wr_cmd)
   );

   // Command queue
   emsf_cmd_fifo u_cmd_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_cmd (wr_cmd),
      .full   (cmd_full),
      .pop    (cmd_pop),
      .rd_cmd (rd_cmd),
      .empty  (cmd_empty)
   );

   // Back: header, payload and CRC emission
   emsf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (cmd_empty),
      .cmd              (rd_cmd),
      .cmd_pop          (cmd_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_section_byte (rsp_section_byte),
      .rsp_section_end  (rsp_section_end)
   );

endmodule

FILE: src/emsf_front.sv
`timescale 1ns / 1ps

module emsf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_frame_byte,
   input  logic [15:0]         req_frame_length,
   input  logic                req_last_byte,
   output logic                req_full,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [11:0]         csr_max_frame_length,
   input  logic                cmd_full,
   output logic                cmd_push,
   output emsf_pkg::cmd_type   cmd
);

   logic [11:0]     max_len_ff;
   logic [15:0]     pos_ff, pos_in;
   logic [5:0][7:0] mac_ff;
   logic [7:0]      etype_hi_ff, etype_hi_in;
   logic            dropped_ff, dropped_in;
   logic            accept;
   logic            keep;
   logic [15:0]     len_full;

   assign req_full  = cmd_full;
   assign csr_ready = 1'b1;
   assign accept    = req_push && !cmd_full;

   // Length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= emsf_pkg::MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_frame_length;
      end
   end

   // Frame checks at the low ethertype byte
   assign len_full = req_frame_length - 16'd1;
   assign keep = (req_frame_length > emsf_pkg::ETH_HDR_BYTES)
              && (req_frame_length <= {4'h0, max_len_ff})
              && (etype_hi_ff == emsf_pkg::ETYPE_IPV4_HI)
              && (req_frame_byte == emsf_pkg::ETYPE_IPV4_LO)
              && !req_last_byte;

   // Classify the byte, build the command
   always_comb begin
      pos_in         = pos_ff;
      etype_hi_in    = etype_hi_ff;
      dropped_in     = dropped_ff;
      cmd_push       = 1'b0;
      cmd.is_hdr     = 1'b0;
      cmd.data       = req_frame_byte;
      cmd.last       = req_last_byte;
      cmd.sec_len    = len_full[11:0];
      cmd.mac        = mac_ff;
      if (accept) begin
         if (!dropped_ff) begin
            if (pos_ff == emsf_pkg::POS_ETYPE_HI) begin
               etype_hi_in = req_frame_byte;
            end else if (pos_ff == emsf_pkg::POS_ETYPE_LO) begin
               if (keep) begin
                  cmd_push   = 1'b1;
                  cmd.is_hdr = 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end else if (pos_ff > emsf_pkg::POS_ETYPE_LO) begin
               cmd_push = 1'b1;
            end
         end
         if (req_last_byte) begin
            pos_in      = '0;
            etype_hi_in = '0;
            dropped_in  = 1'b0;
         end else if (pos_ff != emsf_pkg::POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         etype_hi_ff <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         etype_hi_ff <= etype_hi_in;
         dropped_ff  <= dropped_in;
      end
   end

   // Destination MAC capture, bytes 0..5
   always_ff @(posedge clock) begin
      if (accept && !dropped_ff && (pos_ff < emsf_pkg::MAC_BYTES)) begin
         mac_ff[pos_ff[2:0]] <= req_frame_byte;
      end
   end

endmodule

FILE: src/emsf_cmd_fifo.sv
`timescale 1ns / 1ps

module emsf_cmd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  emsf_pkg::cmd_type   wr_cmd,
   output logic                full,
   input  logic                pop,
   output emsf_pkg::cmd_type   rd_cmd,
   output logic                empty
);

   emsf_pkg::cmd_type                 slot_ff [emsf_pkg::CMD_DEPTH];
   logic [emsf_pkg::CMD_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [emsf_pkg::CMD_PTR_W:0]      count_ff;
   logic                              do_push, do_pop;

   assign full    = (count_ff == (emsf_pkg::CMD_PTR_W + 1)'(emsf_pkg::CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_cmd  = slot_ff[rd_ptr_ff];

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

FILE: src/emsf_back.sv
`timescale 1ns / 1ps

module emsf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_empty,
   input  emsf_pkg::cmd_type   cmd,
   output logic                cmd_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_section_byte,
   output logic                rsp_section_end
);

   emsf_pkg::back_state_type state_ff, state_in;
   emsf_pkg::cmd_type        hold_ff, hold_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic [31:0]              crc_ff, crc_in;
   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_byte_ff, out_byte_in;
   logic                     out_end_ff, out_end_in;
   logic                     adv;
   logic                     emit;
   logic [7:0]               ebyte;
   logic                     eend;
   logic [7:0]               crc_sel;

   assign rsp_empty        = !out_valid_ff;
   assign rsp_section_byte = out_byte_ff;
   assign rsp_section_end  = out_end_ff;

   // Output slot frees when empty or taken this cycle
   assign adv = !out_valid_ff || rsp_pop;

   // CRC trailer byte, most significant first
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    crc_sel = crc_ff[31:24];
         2'd1:    crc_sel = crc_ff[23:16];
         2'd2:    crc_sel = crc_ff[15:8];
         default: crc_sel = crc_ff[7:0];
      endcase
   end

   // Sequencer: one section byte per cycle while the output slot frees
   always_comb begin
      state_in = state_ff;
      hold_in  = hold_ff;
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      cmd_pop  = 1'b0;
      emit     = 1'b0;
      ebyte    = 8'h00;
      eend     = 1'b0;
      case (state_ff)
         emsf_pkg::BK_CMD: begin
            if (adv && !cmd_empty) begin
               cmd_pop = 1'b1;
               emit    = 1'b1;
               if (cmd.is_hdr) begin
                  ebyte    = emsf_pkg::hdr_byte(4'd0, cmd.sec_len, cmd.mac);
                  hold_in  = cmd;
                  cnt_in   = 4'd1;
                  state_in = emsf_pkg::BK_HDR;
               end else begin
                  ebyte = cmd.data;
                  if (cmd.last) begin
                     cnt_in   = 4'd0;
                     state_in = emsf_pkg::BK_CRC;
                  end
               end
               crc_in = emsf_pkg::crc_step(crc_ff, ebyte);
            end
         end
         emsf_pkg::BK_HDR: begin
            if (adv) begin
               emit   = 1'b1;
               ebyte  = emsf_pkg::hdr_byte(cnt_ff, hold_ff.sec_len, hold_ff.mac);
               crc_in = emsf_pkg::crc_step(crc_ff, ebyte);
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == emsf_pkg::HDR_LAST_IDX) begin
                  state_in = emsf_pkg::BK_CMD;
               end
            end
         end
         emsf_pkg::BK_CRC: begin
            if (adv) begin
               emit   = 1'b1;
               ebyte  = crc_sel;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == emsf_pkg::CRC_LAST_IDX) begin
                  eend     = 1'b1;
                  crc_in   = emsf_pkg::CRC_INIT;
                  state_in = emsf_pkg::BK_CMD;
               end
            end
         end
         default: begin
            state_in = emsf_pkg::BK_CMD;
         end
      endcase
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      if (adv) begin
         out_valid_in = emit;
         out_byte_in  = ebyte;
         out_end_in   = eend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= emsf_pkg::BK_CMD;
         cnt_ff       <= '0;
         crc_ff       <= emsf_pkg::CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

endmodule

FILE: tb/ethernet_to_mpe_section_framer_test.sv
`timescale 1ns / 1ps

module ethernet_to_mpe_section_framer_test;

   localparam int DRAIN_CYCLES  = 40;
   localparam int WATCHDOG_MAX  = 3000;
   localparam int PHASE_BYTES   = 40;
   localparam int LONG_BYTES    = 40;
   localparam logic [11:0] PHASE_LIMIT[4] = '{12'd4080, 12'd15, 12'd1500, 12'd64};
   localparam int SEND_IDLE_PCT[4] = '{0, 83, 0, 24};
   localparam int RECV_STALL_PCT[4] = '{0, 0, 83, 24};

   typedef struct {
      logic [7:0]  frame_byte;
      logic [15:0] frame_length;
      logic        last_byte;
   } eth_byte_type;

   typedef struct {
      logic [7:0] data;
      logic       sec_end;
   } section_byte_type;

   typedef logic [7:0] byte_list_type[$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_frame_byte = 8'h00;
   logic [15:0] req_frame_length = 16'h0000;
   logic        req_last_byte = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_section_byte;
   logic        rsp_section_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_max_frame_length = emsf_pkg::MAX_LEN_RESET;

   // stimulus and expectations
   eth_byte_type     pending_bytes[$];
   eth_byte_type     drive_item;
   section_byte_type expected_section[$];
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               mismatch_count = 0;
   int               idle_cycles = 0;

   // framer state as the testbench sees it
   logic [11:0]   max_len_cfg = emsf_pkg::MAX_LEN_RESET;
   logic [15:0]   byte_pos = '0;
   logic [7:0]    dest_mac[6];
   logic [7:0]    etype_hi = '0;
   logic          drop_frame = 1'b0;
   logic [31:0]   section_crc = emsf_pkg::CRC_INIT;

   ethernet_to_mpe_section_framer dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_frame_byte       (req_frame_byte),
      .req_frame_length     (req_frame_length),
      .req_last_byte        (req_last_byte),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_section_byte     (rsp_section_byte),
      .rsp_section_end      (rsp_section_end),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_frame_length (csr_max_frame_length)
   );

   always #5 clock = ~clock;

   // MPEG-2 CRC-32, one byte MSB first, no reflection
   function automatic logic [31:0] crc_after_byte(logic [31:0] crc, logic [7:0] b);
      logic [31:0] acc;
      acc = crc ^ {b, 24'h0};
      for (int k = 0; k < 8; k++) begin
         if (acc[31]) acc = {acc[30:0], 1'b0} ^ emsf_pkg::CRC_POLY;
         else acc = {acc[30:0], 1'b0};
      end
      return acc;
   endfunction

   // section byte that enters the CRC
   task automatic add_section_byte(input logic [7:0] d);
      section_crc = crc_after_byte(section_crc, d);
      expected_section.push_back('{data: d, sec_end: 1'b0});
   endtask

   // work out the section bytes caused by one accepted frame byte
   task automatic frame_to_section(input eth_byte_type it);
      logic [11:0] sec_len;
      logic [7:0]  hdr[12];
      logic [31:0] crc_out;
      logic        keep;
      if (!drop_frame) begin
         if (byte_pos < emsf_pkg::MAC_BYTES) begin
            dest_mac[byte_pos[2:0]] = it.frame_byte;
         end else if (byte_pos == emsf_pkg::POS_ETYPE_HI) begin
            etype_hi = it.frame_byte;
         end else if (byte_pos == emsf_pkg::POS_ETYPE_LO) begin
            keep = it.frame_length > emsf_pkg::ETH_HDR_BYTES
                   && it.frame_length <= {4'h0, max_len_cfg}
                   && etype_hi == emsf_pkg::ETYPE_IPV4_HI
                   && it.frame_byte == emsf_pkg::ETYPE_IPV4_LO
                   && !it.last_byte;
            if (!keep) begin
               drop_frame = 1'b1;
            end else begin
               // section length counts from after the 3-byte section header
               sec_len = it.frame_length[11:0] - 12'd1;
               hdr = '{emsf_pkg::TABLE_ID,
                       emsf_pkg::LEN_FLAGS | {4'h0, sec_len[11:8]}, sec_len[7:0],
                       dest_mac[5], dest_mac[4], emsf_pkg::MPE_FLAGS, 8'h00, 8'h00,
                       dest_mac[3], dest_mac[2], dest_mac[1], dest_mac[0]};
               foreach (hdr[k]) add_section_byte(hdr[k]);
            end
         end else if (byte_pos > emsf_pkg::POS_ETYPE_LO) begin
            add_section_byte(it.frame_byte);
            if (it.last_byte) begin
               crc_out = section_crc;
               expected_section.push_back('{data: crc_out[31:24], sec_end: 1'b0});
               expected_section.push_back('{data: crc_out[23:16], sec_end: 1'b0});
               expected_section.push_back('{data: crc_out[15:8], sec_end: 1'b0});
               expected_section.push_back('{data: crc_out[7:0], sec_end: 1'b1});
            end
         end
      end
      if (it.last_byte) begin
         byte_pos = '0;
         etype_hi = '0;
         drop_frame = 1'b0;
         section_crc = emsf_pkg::CRC_INIT;
      end else if (byte_pos != emsf_pkg::POS_MAX) begin
         byte_pos = byte_pos + 16'd1;
      end
   endtask

   // driver: offers pending bytes, holds each until its transfer
   always @(posedge clock) begin
      logic took;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         took = req_push && !req_full;
         if (took) frame_to_section(drive_item);
         if (!req_push || took) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_item = pending_bytes.pop_front();
               req_push <= 1'b1;
               req_frame_byte <= drive_item.frame_byte;
               req_frame_length <= drive_item.frame_length;
               req_last_byte <= drive_item.last_byte;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each section byte transfer against the oldest expectation
   always @(posedge clock) begin
      section_byte_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_section.size() == 0) begin
               $error("section_byte: expected nothing, got %h", rsp_section_byte);
               mismatch_count++;
            end else begin
               want = expected_section.pop_front();
               if (rsp_section_byte !== want.data) begin
                  $error("section_byte: expected %h, got %h", want.data, rsp_section_byte);
                  mismatch_count++;
               end
               if (rsp_section_end !== want.sec_end) begin
                  $error("section_end: expected %b, got %b", want.sec_end, rsp_section_end);
                  mismatch_count++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $error("no transfer for %0d cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // one frame, last_byte on its final byte
   task automatic queue_frame(input byte_list_type data, input logic [15:0] flen);
      foreach (data[k])
         pending_bytes.push_back('{frame_byte: data[k], frame_length: flen,
                                   last_byte: (k == data.size() - 1)});
   endtask

   // mostly IPv4 frames with random content, plus fragments and other types
   task automatic queue_random_frames(input int budget);
      int            sent;
      int            n;
      int            kind;
      int            pick;
      byte_list_type data;
      logic [15:0]   flen;
      logic [15:0]   lim;
      sent = 0;
      lim = {4'h0, max_len_cfg};
      while (sent < budget) begin
         kind = $urandom_range(99);
         if (kind < 15) n = $urandom_range(14, 1);
         else if ($urandom_range(19) == 0) n = 14;
         else if ($urandom_range(9) == 0) n = 14 + $urandom_range(40, 17);
         else n = 14 + $urandom_range(16, 1);
         data.delete();
         repeat (n) data.push_back(8'($urandom));
         if (kind >= 15) begin
            data[12] = emsf_pkg::ETYPE_IPV4_HI;
            data[13] = emsf_pkg::ETYPE_IPV4_LO;
            if (kind >= 85) begin
               if ($urandom_range(1) == 1) data[12] = 8'($urandom);
               else data[13] = 8'($urandom);
            end
         end
         pick = $urandom_range(99);
         if (pick < 40) flen = 16'(n);
         else if (pick < 60) flen = 16'($urandom_range(lim, 15));
         else if (pick < 70) flen = 16'($urandom_range(14, 0));
         else if (pick < 80) flen = lim;
         else if (pick < 85) flen = lim + 16'd1;
         else flen = 16'($urandom_range(65535, 0));
         queue_frame(data, flen);
         sent += n;
      end
   endtask

   // wait until every byte is transferred and every section byte is back
   task automatic wait_for_idle();
      while (pending_bytes.size() != 0 || req_push || expected_section.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_max_frame_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      max_len_cfg = value;
   endtask

   initial begin
      byte_list_type data;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // shortest kept frame: broadcast MAC, zero source, one zero payload byte
      data.delete();
      repeat (6) data.push_back(8'hff);
      repeat (6) data.push_back(8'h00);
      data.push_back(emsf_pkg::ETYPE_IPV4_HI);
      data.push_back(emsf_pkg::ETYPE_IPV4_LO);
      data.push_back(8'h00);
      queue_frame(data, 16'd15);
      // single-byte fragment
      data = '{8'hff};
      queue_frame(data, 16'hffff);
      // IPv4 frame that ends on the low ethertype byte
      data.delete();
      repeat (12) data.push_back(8'($urandom));
      data.push_back(emsf_pkg::ETYPE_IPV4_HI);
      data.push_back(emsf_pkg::ETYPE_IPV4_LO);
      queue_frame(data, 16'd100);
      wait_for_idle();

      // frame whose length field disagrees with its byte count
      @(negedge clock);
      data.delete();
      repeat (LONG_BYTES) data.push_back(8'($urandom));
      data[12] = emsf_pkg::ETYPE_IPV4_HI;
      data[13] = emsf_pkg::ETYPE_IPV4_LO;
      queue_frame(data, 16'd4080);
      data.delete();
      wait_for_idle();

      // random phases, each behind a full drain and a new length limit
      for (int p = 0; p < 4; p++) begin
         csr_write(PHASE_LIMIT[p]);
         @(negedge clock);
         send_idle_pct = SEND_IDLE_PCT[p];
         recv_stall_pct = RECV_STALL_PCT[p];
         queue_random_frames(PHASE_BYTES);
         wait_for_idle();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
